[rtl/pitst_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point in thick triangle test: shared types and helpers
// Widths of the exact integer datapath and the cross product helper.
// ----------------------------------------------------------------------------
package pitst_pkg;

    localparam int CW         = 16;    // Q8.8 coordinate
    localparam int DW         = CW + 1; // coordinate difference
    localparam int NW         = 35;    // cross product component
    localparam int PW         = 52;    // 17 x 35 product and t * n
    localparam int DISTW      = 54;    // sum of three 17 x 35 products
    localparam int EDW        = 72;    // sum of three 35 x 35 products
    localparam int SPLIT      = 27;    // low half width of a split square
    localparam int HW         = SPLIT + 1; // signed half operand
    localparam int HPW        = 2 * HW;    // half product
    localparam int WW         = 108;   // squared distance and squared bound
    localparam int NUM_STAGES = 7;
    localparam int NUM_IN     = 12;
    localparam int IN_TDATA_W = NUM_IN * CW;
    localparam int OUT_TDATA_W = 8;
    localparam logic [CW-1:0] HALF_THICKNESS_RESET = 16'd256;

    typedef logic signed [CW-1:0]    coord_t;
    typedef logic signed [DW-1:0]    diff_t;
    typedef logic signed [NW-1:0]    nvec_t;
    typedef logic signed [PW-1:0]    prod_t;
    typedef logic signed [DISTW-1:0] dist_t;
    typedef logic signed [EDW-1:0]   edot_t;
    typedef logic signed [HW-1:0]    half_t;
    typedef logic signed [HPW-1:0]   hprod_t;
    typedef logic signed [WW-1:0]    wide_t;

    // One component of a cross product: a1 * b2 - a2 * b1.
    function automatic nvec_t cross_comp(diff_t a1, diff_t b2, diff_t a2, diff_t b1);
        nvec_t p;
        nvec_t q;
        p = nvec_t'(a1) * nvec_t'(b2);
        q = nvec_t'(a2) * nvec_t'(b1);
        return p - q;
    endfunction

    // Reassemble v^2 from v = h * 2^SPLIT + l: h^2 * 2^(2*SPLIT) + h*l * 2^(SPLIT+1) + l^2.
    function automatic wide_t join_square(hprod_t hh, hprod_t hl, hprod_t ll);
        return (wide_t'(hh) <<< (2 * SPLIT)) + (wide_t'(hl) <<< (SPLIT + 1)) + wide_t'(ll);
    endfunction

endpackage

[rtl/point_in_triangle_slab_test_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point in thick triangle test core
// Seven stage pipeline: differences, cross products, products, dot sums,
// split squares, square assembly, and the final slab compare.
// ----------------------------------------------------------------------------
// Throughput is one item per cycle while m_tready is high; each stage holds its item only while the
// stage after it is full and stalled, so bubbles are squeezed out.
// Reset is synchronous and active low; it empties the pipeline and sets
// half_thickness to 256 (1.0 in Q8.8).
module point_in_triangle_slab_test_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [pitst_pkg::CW-1:0]          cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // point_x, point_y, point_z, vertex_a_x..z, vertex_b_x..z, vertex_c_x..z
    input  logic [pitst_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // inside_zone, within_slab, then six zero bits
    output logic [pitst_pkg::OUT_TDATA_W-1:0] m_tdata
);

    localparam int NS = pitst_pkg::NUM_STAGES;

    logic [pitst_pkg::CW-1:0] half_thickness_reg;
    logic [NS:1]              v_reg;
    logic [NS:1]              en;

    // Stage 1
    pitst_pkg::diff_t xa_reg [3], ab_reg [3], ac_reg [3];
    pitst_pkg::diff_t ed_reg [3][3], dd_reg [3][3];
    pitst_pkg::diff_t xa_next [3], ab_next [3], ac_next [3];
    pitst_pkg::diff_t ed_next [3][3], dd_next [3][3];
    // Stage 2
    pitst_pkg::diff_t xa2_reg [3];
    pitst_pkg::nvec_t n_reg [3], c_reg [3][3];
    pitst_pkg::nvec_t n_next [3], c_next [3][3];
    // Stage 3
    pitst_pkg::prod_t  pd_reg [3], ptn_reg [3];
    pitst_pkg::edot_t  pe_reg [3][3];
    logic              deg3_reg;
    pitst_pkg::prod_t  pd_next [3], ptn_next [3];
    pitst_pkg::edot_t  pe_next [3][3];
    logic              deg3_next;
    // Stage 4
    pitst_pkg::dist_t  dist_reg, dist_next;
    pitst_pkg::prod_t  tn_reg [3];
    logic              in4_reg, in4_next, deg4_reg;
    // Stage 5
    pitst_pkg::hprod_t dhh_reg, dhl_reg, dll_reg;
    pitst_pkg::hprod_t dhh_next, dhl_next, dll_next;
    pitst_pkg::hprod_t thh_reg [3], thl_reg [3], tll_reg [3];
    pitst_pkg::hprod_t thh_next [3], thl_next [3], tll_next [3];
    logic              in5_reg, deg5_reg;
    // Stage 6
    pitst_pkg::wide_t  lhs_reg, lhs_next;
    pitst_pkg::wide_t  sq_reg [3], sq_next [3];
    logic              in6_reg, deg6_reg;
    // Stage 7
    logic              inside_zone_reg, within_slab_reg;
    logic              inside_zone_next, within_slab_next;
    pitst_pkg::wide_t  rhs;

    always_comb begin
        en[NS] = !v_reg[NS] || m_tready;
        for (int k = NS - 1; k >= 1; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign s_tready = en[1];
    assign m_tvalid = v_reg[NS];
    assign m_tdata  = {{(pitst_pkg::OUT_TDATA_W - 2){1'b0}}, within_slab_reg, inside_zone_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_thickness_reg <= pitst_pkg::HALF_THICKNESS_RESET;
            v_reg              <= '0;
        end else begin
            if (cfg_wr_en) begin
                half_thickness_reg <= cfg_wr_data;
            end
            if (en[1]) begin
                v_reg[1] <= s_tvalid;
            end
            for (int k = 2; k <= NS; k++) begin
                if (en[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // Stage 1: coordinate differences.
    always_comb begin
        pitst_pkg::diff_t x [3], a [3], b [3], c [3];
        for (int k = 0; k < 3; k++) begin
            x[k] = pitst_pkg::diff_t'(pitst_pkg::coord_t'(s_tdata[pitst_pkg::CW*k +: pitst_pkg::CW]));
            a[k] = pitst_pkg::diff_t'(pitst_pkg::coord_t'(s_tdata[pitst_pkg::CW*(k+3) +: pitst_pkg::CW]));
            b[k] = pitst_pkg::diff_t'(pitst_pkg::coord_t'(s_tdata[pitst_pkg::CW*(k+6) +: pitst_pkg::CW]));
            c[k] = pitst_pkg::diff_t'(pitst_pkg::coord_t'(s_tdata[pitst_pkg::CW*(k+9) +: pitst_pkg::CW]));
        end
        for (int k = 0; k < 3; k++) begin
            xa_next[k]    = x[k] - a[k];
            ab_next[k]    = a[k] - b[k];
            ac_next[k]    = a[k] - c[k];
            ed_next[0][k] = b[k] - a[k];
            ed_next[1][k] = c[k] - b[k];
            ed_next[2][k] = a[k] - c[k];
            dd_next[0][k] = x[k] - a[k];
            dd_next[1][k] = x[k] - b[k];
            dd_next[2][k] = x[k] - c[k];
        end
    end

    // Stage 2: the normal and a cross product for each edge.
    always_comb begin
        n_next[0] = pitst_pkg::cross_comp(ab_reg[1], ac_reg[2], ab_reg[2], ac_reg[1]);
        n_next[1] = pitst_pkg::cross_comp(ab_reg[2], ac_reg[0], ab_reg[0], ac_reg[2]);
        n_next[2] = pitst_pkg::cross_comp(ab_reg[0], ac_reg[1], ab_reg[1], ac_reg[0]);
        for (int j = 0; j < 3; j++) begin
            c_next[j][0] = pitst_pkg::cross_comp(ed_reg[j][1], dd_reg[j][2],
                                                 ed_reg[j][2], dd_reg[j][1]);
            c_next[j][1] = pitst_pkg::cross_comp(ed_reg[j][2], dd_reg[j][0],
                                                 ed_reg[j][0], dd_reg[j][2]);
            c_next[j][2] = pitst_pkg::cross_comp(ed_reg[j][0], dd_reg[j][1],
                                                 ed_reg[j][1], dd_reg[j][0]);
        end
    end

    // Stage 3: products for the plane distance, the scaled normal and the edge dots.
    always_comb begin
        deg3_next = (n_reg[0] == '0) && (n_reg[1] == '0) && (n_reg[2] == '0);
        for (int k = 0; k < 3; k++) begin
            pd_next[k]  = pitst_pkg::prod_t'(xa2_reg[k]) * pitst_pkg::prod_t'(n_reg[k]);
            ptn_next[k] = pitst_pkg::prod_t'({1'b0, half_thickness_reg}) *
                          pitst_pkg::prod_t'(n_reg[k]);
            for (int j = 0; j < 3; j++) begin
                pe_next[j][k] = pitst_pkg::edot_t'(n_reg[k]) * pitst_pkg::edot_t'(c_reg[j][k]);
            end
        end
    end

    // Stage 4: dot product sums.
    always_comb begin
        pitst_pkg::edot_t es;
        dist_next = pitst_pkg::dist_t'(pd_reg[0]) + pitst_pkg::dist_t'(pd_reg[1]) +
                    pitst_pkg::dist_t'(pd_reg[2]);
        in4_next  = 1'b1;
        for (int j = 0; j < 3; j++) begin
            es = pe_reg[j][0] + pe_reg[j][1] + pe_reg[j][2];
            if (es[pitst_pkg::EDW-1]) begin
                in4_next = 1'b0;
            end
        end
    end

    // Stage 5: partial products of the squares, each operand split in two halves.
    always_comb begin
        pitst_pkg::half_t h;
        pitst_pkg::half_t l;
        h        = pitst_pkg::half_t'($signed(dist_reg[pitst_pkg::DISTW-1:pitst_pkg::SPLIT]));
        l        = pitst_pkg::half_t'({1'b0, dist_reg[pitst_pkg::SPLIT-1:0]});
        dhh_next = pitst_pkg::hprod_t'(h) * pitst_pkg::hprod_t'(h);
        dhl_next = pitst_pkg::hprod_t'(h) * pitst_pkg::hprod_t'(l);
        dll_next = pitst_pkg::hprod_t'(l) * pitst_pkg::hprod_t'(l);
        for (int k = 0; k < 3; k++) begin
            h           = pitst_pkg::half_t'($signed(tn_reg[k][pitst_pkg::PW-1:pitst_pkg::SPLIT]));
            l           = pitst_pkg::half_t'({1'b0, tn_reg[k][pitst_pkg::SPLIT-1:0]});
            thh_next[k] = pitst_pkg::hprod_t'(h) * pitst_pkg::hprod_t'(h);
            thl_next[k] = pitst_pkg::hprod_t'(h) * pitst_pkg::hprod_t'(l);
            tll_next[k] = pitst_pkg::hprod_t'(l) * pitst_pkg::hprod_t'(l);
        end
    end

    // Stage 6: assemble the squares.
    always_comb begin
        lhs_next = pitst_pkg::join_square(dhh_reg, dhl_reg, dll_reg);
        for (int k = 0; k < 3; k++) begin
            sq_next[k] = pitst_pkg::join_square(thh_reg[k], thl_reg[k], tll_reg[k]);
        end
    end

    // Stage 7: squared distance against squared bound; a degenerate triangle fails.
    always_comb begin
        rhs              = sq_reg[0] + sq_reg[1] + sq_reg[2];
        within_slab_next = (lhs_reg <= rhs) && !deg6_reg;
        inside_zone_next = within_slab_next && in6_reg;
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            xa_reg <= xa_next;
            ab_reg <= ab_next;
            ac_reg <= ac_next;
            ed_reg <= ed_next;
            dd_reg <= dd_next;
        end
        if (en[2]) begin
            xa2_reg <= xa_reg;
            n_reg   <= n_next;
            c_reg   <= c_next;
        end
        if (en[3]) begin
            pd_reg   <= pd_next;
            ptn_reg  <= ptn_next;
            pe_reg   <= pe_next;
            deg3_reg <= deg3_next;
        end
        if (en[4]) begin
            dist_reg <= dist_next;
            tn_reg   <= ptn_reg;
            in4_reg  <= in4_next;
            deg4_reg <= deg3_reg;
        end
        if (en[5]) begin
            dhh_reg  <= dhh_next;
            dhl_reg  <= dhl_next;
            dll_reg  <= dll_next;
            thh_reg  <= thh_next;
            thl_reg  <= thl_next;
            tll_reg  <= tll_next;
            in5_reg  <= in4_reg;
            deg5_reg <= deg4_reg;
        end
        if (en[6]) begin
            lhs_reg  <= lhs_next;
            sq_reg   <= sq_next;
            in6_reg  <= in5_reg;
            deg6_reg <= deg5_reg;
        end
        if (en[7]) begin
            inside_zone_reg <= inside_zone_next;
            within_slab_reg <= within_slab_next;
        end
    end

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("Output valid after reset.");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> v_reg[1])
        else $error("Accepted transfer did not enter the first stage.");

    a_bubble_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg != '1) |-> s_tready)
        else $error("Input stalled although the pipeline has a free stage.");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[NS-1] && v_reg[NS] && !m_tready) |=> (v_reg[NS-1] && $stable(lhs_reg)))
        else $error("Stage six lost its item during an output stall.");

    a_inside_implies_slab: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tdata[0] || m_tdata[1]))
        else $error("Inside reported outside the slab.");

endmodule
